// ===== rtl/core/lrfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lrfd_pkg
// Shared types and constants of the load ripple fault detector.
// ----------------------------------------------------------------------------
`default_nettype none

package lrfd_pkg;

	// command codes (s_tuser)
	localparam logic [1:0] CMD_STEP  = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_ARM   = 2'd2;

	// clear depths
	localparam logic [1:0] CLR_DISARM = 2'd0;
	localparam logic [1:0] CLR_RESET  = 2'd1;
	localparam logic [1:0] CLR_STOP   = 2'd2;

	// result events
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_FAULT   = 2'd1;
	localparam logic [1:0] EV_RECOVER = 2'd2;

	// configuration register indexes
	localparam logic CFG_ENABLE   = 1'b0;
	localparam logic CFG_RECOVERY = 1'b1;

	localparam logic [15:0] RECOVERY_RESET = 16'd100;

	localparam logic [6:0] LIMIT_FIRST = 7'd64;
	localparam logic [6:0] LIMIT_EARLY = 7'd40;
	localparam logic [6:0] LIMIT_LATE  = 7'd20;
	localparam logic [3:0] WIN_FIRST   = 4'd1;
	localparam logic [3:0] WIN_EARLY   = 4'd2;
	localparam logic [3:0] WIN_LATE    = 4'd9;
	localparam logic [3:0] WIN_LAST    = 4'd11;
	localparam logic [7:0] HIT_MAX     = 8'd255;
	localparam logic [7:0] HIT_EARLY   = 8'd4;
	localparam logic [7:0] HIT_LATE    = 8'd2;
	localparam logic [7:0] PEAK_EMPTY_HIGH = 8'd0;
	localparam logic [7:0] PEAK_EMPTY_LOW  = 8'd255;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] clear_level;
		logic [7:0] peak_high;
		logic [7:0] peak_low;
		logic       other_busy;
	} lrfd_item_t;

	typedef struct packed {
		logic        fault_flag;
		logic [2:0]  kind_marks;
		logic [15:0] hold_timer;
		logic [3:0]  window_count;
		logic [7:0]  hit_count;
		logic [6:0]  limit_value;
		logic        sampling_flag;
		logic        ok_flag;
		logic        armed_flag;
	} lrfd_state_t;

	localparam lrfd_state_t STATE_RESET = '{
		fault_flag: 1'b0, kind_marks: 3'd0, hold_timer: 16'd0, window_count: 4'd0,
		hit_count: 8'd0, limit_value: 7'd0, sampling_flag: 1'b0, ok_flag: 1'b0,
		armed_flag: 1'b0
	};

endpackage

`default_nettype wire

// ===== rtl/core/lrfd_step.sv =====
// ----------------------------------------------------------------------------
// lrfd_step
// Next-state and event logic for one command against the detector state.
// ----------------------------------------------------------------------------
`default_nettype none

module lrfd_step
	import lrfd_pkg::*;
(
	input  wire lrfd_item_t  item,
	input  wire lrfd_state_t cur,
	input  wire              enable,
	input  wire [15:0]       recovery_steps,
	output lrfd_state_t      nxt,
	output logic [1:0]       ev
);

	logic [7:0] diff;
	logic [3:0] win_n;
	logic [6:0] lim_n;
	logic [7:0] hit_base;
	logic [7:0] hit_n;
	logic       win_valid;
	logic       over;

	assign diff      = item.peak_high - item.peak_low;
	assign win_valid = (item.peak_high != PEAK_EMPTY_HIGH) && (item.peak_low != PEAK_EMPTY_LOW);

	always_comb begin
		win_n = cur.window_count;
		lim_n = cur.limit_value;
		if (cur.window_count < WIN_LAST) begin
			win_n = cur.window_count + 4'd1;
			if (win_n == WIN_FIRST)
				lim_n = LIMIT_FIRST;
			else if (win_n == WIN_EARLY)
				lim_n = LIMIT_EARLY;
			else if (win_n == WIN_LATE)
				lim_n = LIMIT_LATE;
		end
	end

	assign over     = diff >= {1'b0, lim_n};
	assign hit_base = (win_n == WIN_LATE) ? 8'd0 : cur.hit_count;
	assign hit_n    = (hit_base != HIT_MAX) ? hit_base + 8'd1 : hit_base;

	always_comb begin
		nxt = cur;
		ev  = EV_NONE;
		case (item.cmd)
			CMD_STEP: begin
				if (enable) begin
					if (cur.fault_flag) begin
						if (cur.hold_timer < recovery_steps) begin
							nxt.hold_timer = cur.hold_timer + 16'd1;
						end else begin
							nxt.hold_timer = 16'd0;
							nxt.fault_flag = 1'b0;
							nxt.kind_marks = 3'd0;
							ev             = EV_RECOVER;
						end
					end else if (!cur.armed_flag) begin
						nxt = cur;
					end else if (!cur.sampling_flag) begin
						if (!item.other_busy)
							nxt.sampling_flag = 1'b1;
					end else if (win_valid) begin
						nxt.window_count = win_n;
						nxt.limit_value  = lim_n;
						if (over) begin
							if (win_n == WIN_FIRST) begin
								nxt.fault_flag    = 1'b1;
								nxt.kind_marks[0] = 1'b1;
							end else begin
								nxt.hit_count = hit_n;
								if (win_n < WIN_LATE) begin
									if (hit_n > HIT_EARLY) begin
										nxt.fault_flag    = 1'b1;
										nxt.kind_marks[1] = 1'b1;
									end
								end else if (hit_n > HIT_LATE) begin
									nxt.fault_flag    = 1'b1;
									nxt.kind_marks[2] = 1'b1;
								end
							end
							ev = nxt.fault_flag ? EV_FAULT : EV_NONE;
						end else begin
							nxt.hit_count = 8'd0;
							if (win_n == WIN_LAST)
								nxt.ok_flag = 1'b1;
						end
					end
				end
			end
			CMD_CLEAR: begin
				if (item.clear_level == CLR_DISARM || item.clear_level == CLR_RESET ||
						item.clear_level == CLR_STOP)
					nxt.sampling_flag = 1'b0;
				if (item.clear_level == CLR_DISARM || item.clear_level == CLR_RESET) begin
					nxt.ok_flag      = 1'b0;
					nxt.window_count = 4'd0;
					nxt.hit_count    = 8'd0;
				end
				if (item.clear_level == CLR_DISARM)
					nxt.armed_flag = 1'b0;
			end
			CMD_ARM: begin
				nxt.armed_flag = 1'b1;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/load_ripple_fault_detector_top.sv =====
// ----------------------------------------------------------------------------
// load_ripple_fault_detector_top
// Window ripple check with staged thresholds, fault hold and recovery.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                        Contents
// s_*       in   tvalid tready tuser tdata       one command per transaction
// m_*       out  tvalid tready tdata             detector status after it
// cfg_*     in   we addr wdata                   enable, recovery_steps
//
// One transaction is accepted per cycle while s_tready is high; it is held in
// the input register, and its result is loaded into the result register, from
// which it is taken. The detector state is updated by the step logic between
// the two registers, so back-to-back commands see the state left by the
// previous one. A stalled m_tready holds the result register and backs up into
// the input register; s_tready falls only when both are full.
// Reset clears all detector state and loads enable = 1, recovery_steps = 100.
// ----------------------------------------------------------------------------
`default_nettype none

module load_ripple_fault_detector_top
	import lrfd_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire [1:0]             s_tuser,   // cmd
	// clear_level[1:0], peak_high[9:2], peak_low[17:10], other_busy[18], zero pad
	input  wire [IN_DATA_W-1:0]   s_tdata,
	output logic                  m_tvalid,
	input  wire                   m_tready,
	// fault[0], fault_kinds[3:1], settled_ok[4], sampling_on[5], event_res[7:6]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  wire                   cfg_we,
	input  wire                   cfg_addr,
	input  wire [15:0]            cfg_wdata
);

	lrfd_item_t  item_s1;
	logic        valid_s1;
	lrfd_state_t state_q;
	lrfd_state_t state_nxt;
	logic [1:0]  ev_nxt;
	logic        enable_q;
	logic [15:0] recovery_q;
	logic        out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic        advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b1;
			recovery_q <= RECOVERY_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ENABLE:   enable_q   <= cfg_wdata[0];
				CFG_RECOVERY: recovery_q <= cfg_wdata;
				default:      enable_q   <= enable_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.cmd         <= s_tuser;
			item_s1.clear_level <= s_tdata[1:0];
			item_s1.peak_high   <= s_tdata[9:2];
			item_s1.peak_low    <= s_tdata[17:10];
			item_s1.other_busy  <= s_tdata[18];
		end
	end

	lrfd_step u_step (
		.item           (item_s1),
		.cur            (state_q),
		.enable         (enable_q),
		.recovery_steps (recovery_q),
		.nxt            (state_nxt),
		.ev             (ev_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_nxt;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_data_q <= {ev_nxt, state_nxt.sampling_flag, state_nxt.ok_flag,
				state_nxt.kind_marks, state_nxt.fault_flag};
	end

	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.window_count <= WIN_LAST)
		else $error("window count past last window");

	a_marks_with_fault: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.fault_flag == (state_q.kind_marks != 3'd0))
		else $error("kind marks disagree with fault flag");

	a_timer_in_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.hold_timer != 16'd0) |-> state_q.fault_flag)
		else $error("hold timer running without fault");

	a_limit_codes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.limit_value == 7'd0 || state_q.limit_value == LIMIT_FIRST ||
		state_q.limit_value == LIMIT_EARLY || state_q.limit_value == LIMIT_LATE)
		else $error("threshold holds an unexpected value");

	a_state_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a transaction");

endmodule

`default_nettype wire
